FILE: hw/rtl/pmsr_pkg.sv
// Shared types, constants and register codes of the piston motor speed regulator
package pmsr_pkg;

  localparam int unsigned PositionBitsDef = 17;
  localparam int unsigned CommandBitsDef  = 10;
  localparam int unsigned CfgDataW        = 16;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CmdW            = CommandBitsDef;
  localparam int unsigned TickW           = 16;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDeadBand  = 3'd0,
    CfgStopCode  = 3'd1,
    CfgUpLimit   = 3'd2,
    CfgDownLimit = 3'd3,
    CfgMinOffset = 3'd4,
    CfgSlewStep  = 3'd5,
    CfgTopStop   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] dead_band;
    logic [CmdW-1:0]  stop_code;
    logic [CmdW-1:0]  up_limit;
    logic [CmdW-1:0]  down_limit;
    logic [CmdW-1:0]  min_offset;
    logic [CmdW-1:0]  slew_step;
    logic [TickW-1:0] top_stop;
  } cfg_t;

  localparam cfg_t CfgRst = '{
    dead_band:  16'd50,
    stop_code:  10'd150,
    up_limit:   10'd200,
    down_limit: 10'd100,
    min_offset: 10'd10,
    slew_step:  10'd1,
    top_stop:   16'd2400
  };

  localparam logic [CmdW-1:0] CommandRst = 10'd150;

  typedef struct packed {
    logic [CmdW-1:0] target;
    logic            force_stop;
    logic            top;
    logic            bottom;
  } mid_item_t;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [CmdW-1:0] target;
    logic            top;
    logic            bottom;
  } result_t;

endpackage

FILE: hw/rtl/pmsr_fifo.sv
// Small register queue used between the regulator stages and at the result side
module pmsr_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned Depth  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t rdata_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t         mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/pmsr_front.sv
// Front pipeline: position error, dead band, exact 3/10 scaling, target and end stop class
module pmsr_front import pmsr_pkg::*; #(
  parameter int unsigned PositionBits = PositionBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [PositionBits-1:0] piston_position_i,
  input  logic        [TickW-1:0]        target_position_i,
  input  cfg_t                           cfg_i,
  output logic                           item_valid_o,
  input  logic                           item_ready_i,
  output mid_item_t                      item_o
);

  localparam int unsigned ErrW  = ((PositionBits > TickW + 1) ? PositionBits : TickW + 1) + 1;
  localparam int unsigned MagW  = ErrW + 2;
  localparam int unsigned Shift = MagW + 4;
  localparam int unsigned ProdW = MagW + Shift;
  localparam logic [Shift:0]   RecipOne = {1'b1, {Shift{1'b0}}};
  localparam logic [Shift-1:0] Recip    = Shift'(RecipOne / 10);

  logic signed [ErrW-1:0] pos_ext, tgt_ext, err;
  logic [ErrW-1:0]        mag;
  logic [MagW-1:0]        scaled;
  logic                   neg, drive, top, bottom;

  logic                   s1_valid_q, s2_valid_q;
  logic [MagW-1:0]        s1_u_q, s2_u_q, s2_q0_q;
  logic                   s1_neg_q, s1_drive_q, s1_top_q, s1_bottom_q;
  logic                   s2_neg_q, s2_drive_q, s2_top_q, s2_bottom_q;
  logic                   ready1, ready2;

  logic [ProdW-1:0]       prod;
  logic [MagW-1:0]        q0, rem, quot, drive_mag;
  logic [MagW:0]          up_sum, down_diff;
  logic [CmdW-1:0]        target;

  // classify
  always_comb begin
    pos_ext = ErrW'(piston_position_i);
    tgt_ext = ErrW'(target_position_i);
    err     = tgt_ext - pos_ext;
    neg     = err[ErrW-1];
    mag     = neg ? ErrW'(-err) : ErrW'(err);
    drive   = mag > ErrW'(cfg_i.dead_band);
    scaled  = (MagW'(mag) << 1) + MagW'(mag) + (neg ? MagW'(9) : '0);
    top     = pos_ext >= $signed(ErrW'(cfg_i.top_stop));
    bottom  = pos_ext[ErrW-1] || (pos_ext == '0);
  end

  assign ready2  = !s2_valid_q || item_ready_i;
  assign ready1  = !s1_valid_q || ready2;
  assign ready_o = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (ready1) begin
        s1_valid_q <= valid_i;
      end
      if (ready2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // reciprocal multiply for the division by ten
  assign prod = ProdW'(s1_u_q) * ProdW'(Recip);
  assign q0   = prod[ProdW-1:Shift];

  always_ff @(posedge clk_i) begin
    if (ready1 && valid_i) begin
      s1_u_q      <= scaled;
      s1_neg_q    <= neg;
      s1_drive_q  <= drive;
      s1_top_q    <= top;
      s1_bottom_q <= bottom;
    end
    if (ready2 && s1_valid_q) begin
      s2_q0_q     <= q0;
      s2_u_q      <= s1_u_q;
      s2_neg_q    <= s1_neg_q;
      s2_drive_q  <= s1_drive_q;
      s2_top_q    <= s1_top_q;
      s2_bottom_q <= s1_bottom_q;
    end
  end

  // correct quotient, push outward, offset from stop and clamp
  always_comb begin
    rem       = s2_u_q - ((s2_q0_q << 3) + (s2_q0_q << 1));
    quot      = s2_q0_q + ((rem >= MagW'(10)) ? MagW'(1) : '0);
    drive_mag = (quot < MagW'(cfg_i.min_offset)) ? MagW'(cfg_i.min_offset) : quot;
    up_sum    = (MagW+1)'(drive_mag) + (MagW+1)'(cfg_i.stop_code);
    down_diff = (MagW+1)'(cfg_i.stop_code) - (MagW+1)'(drive_mag);
    if (!s2_drive_q) begin
      target = cfg_i.stop_code;
    end else if (!s2_neg_q) begin
      target = (up_sum > (MagW+1)'(cfg_i.up_limit)) ? cfg_i.up_limit : up_sum[CmdW-1:0];
    end else begin
      target = ((MagW+1)'(cfg_i.stop_code) <
                (MagW+1)'(drive_mag) + (MagW+1)'(cfg_i.down_limit)) ?
               cfg_i.down_limit : down_diff[CmdW-1:0];
    end
    item_o.target     = target;
    item_o.force_stop = ((target < cfg_i.stop_code) && s2_bottom_q) ||
                        ((target > cfg_i.stop_code) && s2_top_q);
    item_o.top        = s2_top_q;
    item_o.bottom     = s2_bottom_q;
  end

  assign item_valid_o = s2_valid_q;

endmodule

FILE: hw/rtl/pmsr_back.sv
// Back end: slew-limited command update and end stop override
module pmsr_back import pmsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  mid_item_t item_i,
  output logic      item_pop_o,
  input  cfg_t      cfg_i,
  input  logic      result_ready_i,
  output logic      result_valid_o,
  output result_t   result_o
);

  logic [CmdW-1:0]   command_q, command_d;
  logic [CmdW-1:0]   slewed, gap;
  logic              go, rising;

  assign go             = item_valid_i && result_ready_i;
  assign item_pop_o     = go;
  assign result_valid_o = go;

  always_comb begin
    rising = item_i.target > command_q;
    gap    = rising ? (item_i.target - command_q) : (command_q - item_i.target);
    if (gap > cfg_i.slew_step) begin
      slewed = rising ? (command_q + cfg_i.slew_step) : (command_q - cfg_i.slew_step);
    end else begin
      slewed = item_i.target;
    end
    command_d = command_q;
    if (go) begin
      command_d = item_i.force_stop ? cfg_i.stop_code : slewed;
    end
    result_o.command = command_d;
    result_o.target  = item_i.target;
    result_o.top     = item_i.top;
    result_o.bottom  = item_i.bottom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_q <= CommandRst;
    end else begin
      command_q <= command_d;
    end
  end

endmodule

FILE: hw/rtl/piston_motor_speed_regulator.sv
// Top level of the piston motor speed regulator
// One result per accepted tick, one tick accepted per cycle sustained while the result queue
// is popped. A tick's result passes through the first front stage (error and dead band), which
// is loaded at the edge that accepts it, then the second front stage (reciprocal multiply for
// the exact 3/10 gain), the front-to-back queue and the result queue, which the command update
// loop in the back end fills, and then shows on the output ports.
// Up to six ticks may be held inside; full is high while both front stages hold a tick and
// the front-to-back queue is full. Register writes take effect at once and are meant for
// idle periods only.
module piston_motor_speed_regulator import pmsr_pkg::*; #(
  parameter int unsigned PositionBits = PositionBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CfgIdxW-1:0]             cfg_idx_i,
  input  logic [CfgDataW-1:0]            cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic signed [PositionBits-1:0] piston_position_i,
  input  logic [TickW-1:0]               target_position_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [CmdW-1:0]                motor_command_o,
  output logic [CmdW-1:0]                speed_target_o,
  output logic                           top_switch_o,
  output logic                           bottom_switch_o
);

  cfg_t      cfg_q;
  logic      front_ready;
  logic      mid_valid, mid_full, mid_empty, mid_pop;
  mid_item_t mid_wdata, mid_rdata;
  logic      res_valid, res_full;
  result_t   res_wdata, res_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgDeadBand:  cfg_q.dead_band  <= cfg_wdata_i[TickW-1:0];
        CfgStopCode:  cfg_q.stop_code  <= cfg_wdata_i[CmdW-1:0];
        CfgUpLimit:   cfg_q.up_limit   <= cfg_wdata_i[CmdW-1:0];
        CfgDownLimit: cfg_q.down_limit <= cfg_wdata_i[CmdW-1:0];
        CfgMinOffset: cfg_q.min_offset <= cfg_wdata_i[CmdW-1:0];
        CfgSlewStep:  cfg_q.slew_step  <= cfg_wdata_i[CmdW-1:0];
        CfgTopStop:   cfg_q.top_stop   <= cfg_wdata_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  assign full = !front_ready;

  pmsr_front #(
    .PositionBits(PositionBits)
  ) u_front (
    .clk_i,
    .rst_ni,
    .valid_i           (push),
    .ready_o           (front_ready),
    .piston_position_i,
    .target_position_i,
    .cfg_i             (cfg_q),
    .item_valid_o      (mid_valid),
    .item_ready_i      (!mid_full),
    .item_o            (mid_wdata)
  );

  pmsr_fifo #(
    .item_t(mid_item_t),
    .Depth (QueueDepth)
  ) u_mid_fifo (
    .clk_i,
    .rst_ni,
    .push_i (mid_valid),
    .wdata_i(mid_wdata),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .empty_o(mid_empty),
    .rdata_o(mid_rdata)
  );

  pmsr_back u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i  (!mid_empty),
    .item_i        (mid_rdata),
    .item_pop_o    (mid_pop),
    .cfg_i         (cfg_q),
    .result_ready_i(!res_full),
    .result_valid_o(res_valid),
    .result_o      (res_wdata)
  );

  pmsr_fifo #(
    .item_t(result_t),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i,
    .rst_ni,
    .push_i (res_valid),
    .wdata_i(res_wdata),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(res_rdata)
  );

  assign motor_command_o = res_rdata.command;
  assign speed_target_o  = res_rdata.target;
  assign top_switch_o    = res_rdata.top;
  assign bottom_switch_o = res_rdata.bottom;

endmodule

FILE: hw/rtl/pmsr_checker.sv
// Port-level checker of the piston motor speed regulator and its bind
module pmsr_checker import pmsr_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            push,
  input logic            full,
  input logic            empty,
  input logic            pop,
  input logic [CmdW-1:0] motor_command_o,
  input logic [CmdW-1:0] speed_target_o,
  input logic            top_switch_o,
  input logic            bottom_switch_o
);

  localparam int unsigned Capacity = 2 + 2 * QueueDepth;

  logic [3:0] pend_q, pend_d;
  logic       in_txn, out_txn;

  assign in_txn  = push && !full;
  assign out_txn = pop && !empty;

  always_comb begin
    pend_d = pend_q;
    case ({in_txn, out_txn})
      2'b10:   pend_d = pend_q + 1'b1;
      2'b01:   pend_d = pend_q - 1'b1;
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != '0))
    else $error("result shown without a pending transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == '0) |-> !full)
    else $error("full raised with nothing held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(Capacity))
    else $error("more transactions held than the block can store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(motor_command_o) && $stable(speed_target_o) &&
                          $stable(top_switch_o) && $stable(bottom_switch_o)))
    else $error("waiting result changed or vanished");

endmodule

bind piston_motor_speed_regulator pmsr_checker u_pmsr_checker (.*);
